>>> rtl/lfmv_pkg.sv
package lfmv_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int OPERAND_W   = 32;
  localparam int PROD_W      = 2 * OPERAND_W;
  localparam int FRAC_W      = 16;
  localparam int DIM_W       = 4;
  localparam int SEL_W       = 3;
  localparam int LEN_W       = 4;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd1;
  localparam logic             REG_DIMENSION = 1'b0;

  typedef enum logic {
    ACT_COEF = 1'b0,
    ACT_VEC  = 1'b1
  } action_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_LEN_ERR = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_LOAD,
    ST_ERR
  } ctrl_state_e;

  typedef struct packed {
    logic wr_coef;
    logic wr_vec;
    logic issue;
    logic first;
    logic last;
    logic load_row;
    logic last_row;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/lfmv_intf.sv
interface lfmv_in_if;
  logic                                     valid;
  logic                                     ready;
  lfmv_pkg::action_e                        action;
  logic        [lfmv_pkg::SEL_W-1:0]        row_sel;
  logic        [lfmv_pkg::SEL_W-1:0]        col_sel;
  logic signed [lfmv_pkg::OPERAND_W-1:0]    operand;
  logic        [lfmv_pkg::LEN_W-1:0]        vec_len;
  logic                                     vec_last;

  modport source (output valid, action, row_sel, col_sel, operand, vec_len, vec_last,
                  input ready);
  modport sink (input valid, action, row_sel, col_sel, operand, vec_len, vec_last,
                output ready);
endinterface

interface lfmv_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [lfmv_pkg::SEL_W-1:0]        row_out;
  logic signed [lfmv_pkg::OPERAND_W-1:0]    derivative;
  lfmv_pkg::status_e                        status;
  logic                                     out_last;

  modport source (output valid, row_out, derivative, status, out_last, input ready);
  modport sink (input valid, row_out, derivative, status, out_last, output ready);
endinterface

>>> rtl/lfmv_ctrl.sv
module lfmv_ctrl #(
  parameter int MAX_DIM = lfmv_pkg::MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  lfmv_pkg::action_e             in_action_i,
  input  logic                          in_last_i,
  input  logic [lfmv_pkg::LEN_W-1:0]    in_len_i,
  input  logic [lfmv_pkg::DIM_W-1:0]    dim_i,
  input  lfmv_pkg::sts_t                sts_i,
  output logic                          in_ready_o,
  output lfmv_pkg::cmd_t                cmd_o,
  output logic [IDX_W-1:0]              row_o,
  output logic [IDX_W-1:0]              col_o
);
  import lfmv_pkg::*;

  localparam int CW = IDX_W + DIM_W + 1;
  localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] col_q, col_d;
  logic             accept;
  logic             dim_bad;
  logic             col_end;
  logic             row_end;

  assign accept  = in_valid_i && in_ready_o;
  assign dim_bad = (dim_i == '0) || (CW'(dim_i) > MAX_DIM_C) ||
                   (CW'(in_len_i) != CW'(dim_i));
  assign col_end = (CW'(col_q) + CW'(1)) == CW'(dim_i);
  assign row_end = (CW'(row_q) + CW'(1)) == CW'(dim_i);
  assign row_o   = row_q;
  assign col_o   = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.wr_coef = (in_action_i == ACT_COEF);
          cmd_o.wr_vec  = (in_action_i == ACT_VEC);
          if (in_action_i == ACT_VEC && in_last_i) begin
            if (dim_bad) begin
              state_d = ST_ERR;
            end else begin
              row_d   = '0;
              col_d   = '0;
              state_d = ST_ISSUE;
            end
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (col_q == '0);
        cmd_o.last  = col_end;
        col_d       = col_q + IDX_W'(1);
        if (col_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.acc_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_row = 1'b1;
          cmd_o.last_row = row_end;
          if (row_end) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + IDX_W'(1);
            col_d   = '0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lfmv_dpath.sv
module lfmv_dpath #(
  parameter int MAX_DIM = lfmv_pkg::MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfmv_pkg::cmd_t                        cmd_i,
  input  logic        [IDX_W-1:0]               row_i,
  input  logic        [IDX_W-1:0]               col_i,
  input  logic        [lfmv_pkg::SEL_W-1:0]     in_row_sel_i,
  input  logic        [lfmv_pkg::SEL_W-1:0]     in_col_sel_i,
  input  logic signed [lfmv_pkg::OPERAND_W-1:0] in_operand_i,
  input  logic                                  out_ready_i,
  output lfmv_pkg::sts_t                        sts_o,
  output logic                                  out_valid_o,
  output logic        [lfmv_pkg::SEL_W-1:0]     out_row_o,
  output logic signed [lfmv_pkg::OPERAND_W-1:0] out_derivative_o,
  output lfmv_pkg::status_e                     out_status_o,
  output logic                                  out_last_o
);
  import lfmv_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = PROD_W + IDX_W;
  localparam int HI_LO = OPERAND_W + FRAC_W - 1;

  localparam logic signed [OPERAND_W-1:0] SAT_MAX = {1'b0, {(OPERAND_W-1){1'b1}}};
  localparam logic signed [OPERAND_W-1:0] SAT_MIN = {1'b1, {(OPERAND_W-1){1'b0}}};

  logic signed [OPERAND_W-1:0] coef_mem [DEPTH];
  logic signed [OPERAND_W-1:0] vec_mem  [MAX_DIM];

  logic signed [OPERAND_W-1:0] coef_q;
  logic signed [OPERAND_W-1:0] x_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic                        s1_vld_q, s1_first_q, s1_last_q;
  logic                        s2_vld_q, s2_first_q, s2_last_q;
  logic                        out_vld_q;
  logic [SEL_W-1:0]            out_row_q;
  logic signed [OPERAND_W-1:0] out_der_q;
  status_e                     out_status_q;
  logic                        out_last_q;

  logic                        wr_ok;
  logic                        vec_ok;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [ACC_W-HI_LO-1:0]      acc_hi;
  logic signed [OPERAND_W-1:0] sat_val;

  assign wr_ok   = (int'(in_row_sel_i) < MAX_DIM) && (int'(in_col_sel_i) < MAX_DIM);
  assign vec_ok  = int'(in_col_sel_i) < MAX_DIM;
  assign wr_addr = AW'(int'(in_row_sel_i) * MAX_DIM + int'(in_col_sel_i));
  assign rd_addr = AW'(int'(row_i) * MAX_DIM + int'(col_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_coef && wr_ok) begin
      coef_mem[wr_addr] <= in_operand_i;
    end
    if (cmd_i.issue) begin
      coef_q <= coef_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_vec && vec_ok) begin
      vec_mem[IDX_W'(in_col_sel_i)] <= in_operand_i;
    end
    if (cmd_i.issue) begin
      x_q <= vec_mem[col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.load_row || cmd_i.load_err) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    prod_q     <= coef_q * x_q;
    if (s2_vld_q) begin
      if (s2_first_q) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_hi = acc_q[ACC_W-1:HI_LO];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_val = acc_q[HI_LO:FRAC_W];
    end else if (acc_q[ACC_W-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      out_row_q    <= SEL_W'(row_i);
      out_der_q    <= sat_val;
      out_status_q <= STATUS_OK;
      out_last_q   <= cmd_i.last_row;
    end else if (cmd_i.load_err) begin
      out_row_q    <= '0;
      out_der_q    <= '0;
      out_status_q <= STATUS_LEN_ERR;
      out_last_q   <= 1'b1;
    end
  end

  assign sts_o.acc_done = s2_vld_q && s2_last_q;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o      = out_vld_q;
  assign out_row_o        = out_row_q;
  assign out_derivative_o = out_der_q;
  assign out_status_o     = out_status_q;
  assign out_last_o       = out_last_q;

endmodule

>>> rtl/linear_flow_matrix_vector_product.sv
// Channel   Dir   Protocol        Payload
// in_i      in    valid/ready     action, row_sel, col_sel, operand, vec_len, vec_last
// out_o     out   valid/ready     row_out, derivative, status, out_last
// apb       in    APB write/read  dimension at byte address 0
//
// A coefficient write or a non-last element is written while the controller stays idle.
// On a last element one multiply-accumulate unit walks each row column by column,
// then its pipeline drains and the row result is loaded into the output register.
// An error run loads a length-error status. Reset clears the controller and output valid.
// A stalled output holds the pending item while the next row is computed.
module linear_flow_matrix_vector_product #(
  parameter int MAX_DIM = lfmv_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfmv_in_if.sink                       in_i,
  lfmv_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfmv_pkg::APB_AW-1:0]   paddr,
  input  logic [lfmv_pkg::APB_DW-1:0]   pwdata,
  output logic [lfmv_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lfmv_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DIM_W-1:0] dim_q;
  logic             reg_sel;
  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_DIMENSION);
  assign prdata  = reg_sel ? APB_DW'(dim_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dim_q <= pwdata[DIM_W-1:0];
    end
  end

  lfmv_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_last_i   (in_i.vec_last),
    .in_len_i    (in_i.vec_len),
    .dim_i       (dim_q),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd),
    .row_o       (row),
    .col_o       (col)
  );

  lfmv_dpath #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .row_i            (row),
    .col_i            (col),
    .in_row_sel_i     (in_i.row_sel),
    .in_col_sel_i     (in_i.col_sel),
    .in_operand_i     (in_i.operand),
    .out_ready_i      (out_o.ready),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_row_o        (out_o.row_out),
    .out_derivative_o (out_o.derivative),
    .out_status_o     (out_o.status),
    .out_last_o       (out_o.out_last)
  );

endmodule
